### rtl/gwa_pkg.sv
// ----------------------------------------------------------------------------
// gwa_pkg
// Shared widths, payload types, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gwa_pkg;

  localparam int CELL_STATES_W = 40;
  localparam int CELL_ENERGY_W = 20;
  localparam int GRAIN_STATES_W = 44;
  localparam int WSUM_W = 64;
  localparam int GRAIN_SIZE_W = 4;
  localparam int GRAIN_COUNT_W = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 16;

  // The cell states are multiplied in two halves of this many bits.
  localparam int MUL_SPLIT = 20;
  localparam int PROD_W = MUL_SPLIT + CELL_ENERGY_W;

  // Quotient bits produced by the divider, one per cycle.
  localparam int DIV_STEPS = CELL_ENERGY_W;
  localparam int DIV_STEP_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_GRAIN_SIZE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_GRAIN_COUNT = CFG_INDEX_W'(1);

  typedef struct packed {
    logic [CELL_STATES_W-1:0] cell_states;
    logic [CELL_ENERGY_W-1:0] cell_energy;
  } cell_t;

  typedef struct packed {
    logic [GRAIN_STATES_W-1:0] grain_states;
    logic [CELL_ENERGY_W-1:0]  grain_mean_energy;
    logic [GRAIN_COUNT_W-1:0]  grain_position;
    logic                      grain_empty;
    logic                      final_grain;
    logic                      grains_short;
  } grain_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_ADD_LO,
    ST_ADD_HI,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic add_lo;
    logic add_hi;
    logic check;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic sum_zero;
    logic overflow;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### rtl/gwa_stream_if.sv
// ----------------------------------------------------------------------------
// gwa_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
interface gwa_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

### rtl/gwa_ctrl.sv
// ----------------------------------------------------------------------------
// gwa_ctrl
// Sequencer: accepts a cell, steps the multiply and accumulate, and on a grain
// close runs the check, the divider and the result load.
// ----------------------------------------------------------------------------
module gwa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gwa_pkg::status_t status,
  output gwa_pkg::cmd_t    cmd
);
  import gwa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_ADD_LO;
      end
      ST_ADD_LO: begin
        cmd.add_lo = 1'b1;
        state_next = ST_ADD_HI;
      end
      ST_ADD_HI: begin
        cmd.add_hi = 1'b1;
        state_next = status.close ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        // empty grain or saturated mean needs no division
        state_next = (status.sum_zero || status.overflow) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        cmd.finish = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/gwa_datapath.sv
// ----------------------------------------------------------------------------
// gwa_datapath
// Configuration registers, split multiplier, saturating accumulators, grain
// counters, restoring divider and the result register.
// ----------------------------------------------------------------------------
module gwa_datapath #(
  parameter int STATE_BITS = 40,
  parameter int ENERGY_BITS = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  gwa_pkg::cell_t   cell_data,
  input  logic             cfg_valid,
  input  gwa_pkg::cfg_t    cfg_payload,
  input  gwa_pkg::cmd_t    cmd,
  output gwa_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_ready,
  output gwa_pkg::grain_t  out_payload
);
  import gwa_pkg::*;

  localparam int SB = (STATE_BITS > CELL_STATES_W) ? CELL_STATES_W : STATE_BITS;
  localparam int EB = (ENERGY_BITS > CELL_ENERGY_W) ? CELL_ENERGY_W : ENERGY_BITS;
  localparam logic [CELL_STATES_W-1:0] STATE_MASK =
    {CELL_STATES_W{1'b1}} >> (CELL_STATES_W - SB);
  localparam logic [CELL_ENERGY_W-1:0] ENERGY_MAX =
    {CELL_ENERGY_W{1'b1}} >> (CELL_ENERGY_W - EB);
  localparam logic [GRAIN_STATES_W-1:0] SUM_MAX = '1;
  localparam logic [WSUM_W-1:0] WSUM_MAX = '1;

  // configuration
  logic [GRAIN_SIZE_W-1:0]  grain_size;
  logic [GRAIN_COUNT_W-1:0] grain_count;
  logic [GRAIN_SIZE_W-1:0]  size_eff;
  logic [GRAIN_COUNT_W-1:0] count_eff;

  // operands and product
  logic [CELL_STATES_W-1:0] st;
  logic [CELL_ENERGY_W-1:0] en;
  logic [PROD_W-1:0]        prod;

  // grain state
  logic [GRAIN_SIZE_W-1:0]   cell_in_grain;
  logic [GRAIN_COUNT_W-1:0]  grains_seen;
  logic [GRAIN_COUNT_W-1:0]  grains_produced;
  logic [GRAIN_STATES_W-1:0] states_sum;
  logic [WSUM_W-1:0]         weighted_sum;

  // divider
  logic [WSUM_W-1:0]        rem;
  logic [WSUM_W-1:0]        dvs;
  logic [CELL_ENERGY_W-1:0] quo;
  logic [DIV_STEP_W-1:0]    step;

  logic [GRAIN_SIZE_W-1:0]   cell_next;
  logic [WSUM_W:0]           wsum_lo;
  logic [WSUM_W:0]           wsum_hi;
  logic [GRAIN_STATES_W:0]   ssum;
  logic [WSUM_W-1:0]         sum_scaled;
  logic                      rem_ge;
  logic [GRAIN_COUNT_W-1:0]  produced_next;
  logic [GRAIN_COUNT_W-1:0]  seen_next;
  logic                      fin;
  logic [CELL_ENERGY_W-1:0]  mean;

  assign size_eff = (grain_size == '0) ? GRAIN_SIZE_W'(1) : grain_size;
  assign count_eff = (grain_count == '0) ? GRAIN_COUNT_W'(1) : grain_count;

  assign cell_next = cell_in_grain + GRAIN_SIZE_W'(1);
  assign wsum_lo = {1'b0, weighted_sum} + (WSUM_W + 1)'(prod);
  assign wsum_hi = {1'b0, weighted_sum} + {(WSUM_W + 1 - PROD_W - MUL_SPLIT)'(0),
                                           prod, MUL_SPLIT'(0)};
  assign ssum = {1'b0, states_sum} + (GRAIN_STATES_W + 1)'(st);
  assign sum_scaled = {states_sum, CELL_ENERGY_W'(0)};
  assign rem_ge = (rem >= dvs);

  assign produced_next = grains_produced + GRAIN_COUNT_W'(!status.sum_zero);
  assign seen_next = grains_seen + GRAIN_COUNT_W'(1);
  assign fin = (seen_next == '0) || (seen_next >= count_eff);
  assign mean = status.sum_zero ? '0 : ((quo > ENERGY_MAX) ? ENERGY_MAX : quo);

  assign status.close = (cell_next == '0) || (cell_next >= size_eff);
  assign status.sum_zero = (states_sum == '0);
  assign status.overflow = (weighted_sum >= sum_scaled);
  assign status.div_done = (step == '0);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grain_size <= GRAIN_SIZE_W'(1);
      grain_count <= GRAIN_COUNT_W'(1);
    end else if (cfg_valid) begin
      if (cfg_payload.index == REG_GRAIN_SIZE) begin
        grain_size <= cfg_payload.data[GRAIN_SIZE_W-1:0];
      end else if (cfg_payload.index == REG_GRAIN_COUNT) begin
        grain_count <= cfg_payload.data[GRAIN_COUNT_W-1:0];
      end
    end
  end

  // operands, product and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st <= cell_data.cell_states & STATE_MASK;
      en <= cell_data.cell_energy & ENERGY_MAX;
    end
    if (cmd.mul_lo) begin
      prod <= PROD_W'(st[MUL_SPLIT-1:0]) * PROD_W'(en);
    end
    if (cmd.add_lo) begin
      prod <= PROD_W'(st[CELL_STATES_W-1:MUL_SPLIT]) * PROD_W'(en);
    end
    if (cmd.check) begin
      rem <= weighted_sum;
      dvs <= {1'b0, states_sum, (CELL_ENERGY_W - 1)'(0)};
      quo <= status.overflow ? '1 : '0;
      step <= DIV_STEP_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= rem - dvs;
      end
      quo <= {quo[CELL_ENERGY_W-2:0], rem_ge};
      dvs <= dvs >> 1;
      step <= step - DIV_STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_in_grain <= '0;
      grains_seen <= '0;
      grains_produced <= '0;
      states_sum <= '0;
      weighted_sum <= '0;
    end else begin
      if (cmd.add_lo) begin
        weighted_sum <= wsum_lo[WSUM_W] ? WSUM_MAX : wsum_lo[WSUM_W-1:0];
      end
      if (cmd.add_hi) begin
        weighted_sum <= wsum_hi[WSUM_W] ? WSUM_MAX : wsum_hi[WSUM_W-1:0];
        states_sum <= ssum[GRAIN_STATES_W] ? SUM_MAX : ssum[GRAIN_STATES_W-1:0];
        if (!status.close) begin
          cell_in_grain <= cell_next;
        end
      end
      if (cmd.finish) begin
        cell_in_grain <= '0;
        states_sum <= '0;
        weighted_sum <= '0;
        grains_seen <= fin ? '0 : seen_next;
        grains_produced <= fin ? '0 : produced_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_payload.grain_states <= states_sum;
      out_payload.grain_mean_energy <= mean;
      out_payload.grain_position <= grains_produced;
      out_payload.grain_empty <= status.sum_zero;
      out_payload.final_grain <= fin;
      out_payload.grains_short <= fin && (produced_next < count_eff);
    end
  end

endmodule

### rtl/grain_weighted_average.sv
// A cell that does not close a grain passes load, low multiply, low add and high add;
// a closing cell then runs the check, the one-bit-per-cycle divider (skipped when the
// grain is empty or its mean saturates) and the finish step, which loads the result
// register once the output is free; a new cell is taken only when the last is through.
// Reset: synchronous; grain_size and grain_count return to 1, all sums and counters to zero.
// ----------------------------------------------------------------------------
// grain_weighted_average
// Groups cells into grains and emits per grain the saturating state sum and the
// truncated energy-weighted mean, with compacted position and end-of-run flags.
// ----------------------------------------------------------------------------
module grain_weighted_average #(
  parameter int STATE_BITS = 40,
  parameter int ENERGY_BITS = 20
) (
  input logic             clk,
  input logic             rst,
  gwa_stream_if.sink      cells,
  gwa_stream_if.source    grains,
  gwa_stream_if.sink      cfg
);
  import gwa_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign cells.ready = in_ready;
  assign cfg.ready = 1'b1;

  gwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cells.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gwa_datapath #(
    .STATE_BITS  (STATE_BITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cell_data   (cells.payload),
    .cfg_valid   (cfg.valid),
    .cfg_payload (cfg.payload),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (grains.valid),
    .out_ready   (grains.ready),
    .out_payload (grains.payload)
  );

endmodule

### test/grain_weighted_average_test.sv
// ----------------------------------------------------------------------------
// grain_weighted_average_test
// Drives cells and register writes into grain_weighted_average and checks
// every grain against a cycle-free predictor of the grain sums, mean energy,
// compacted position and end-of-run flags. A short table of directed cells
// runs first, followed by random phases under random source and sink stalls
// and one long sink hold-off.
// ----------------------------------------------------------------------------
module grain_weighted_average_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gwa_pkg::*;

  localparam int TOTAL_CELLS = 830;
  localparam int QUIET_FROM = 720;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 40;

  localparam logic [CELL_STATES_W-1:0] MAX_STATES = '1;
  localparam logic [CELL_ENERGY_W-1:0] MAX_ENERGY = '1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

  typedef enum logic {ROW_CELL, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_t      write;
    cell_t     cell_data;
    bit        typed;
    grain_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  gwa_stream_if #(.payload_t(cell_t))  cells_if ();
  gwa_stream_if #(.payload_t(grain_t)) grains_if ();
  gwa_stream_if #(.payload_t(cfg_t))   cfg_if ();

  grain_weighted_average dut (
    .clk    (clk),
    .rst    (rst),
    .cells  (cells_if),
    .grains (grains_if),
    .cfg    (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int unsigned cycles = 0;
  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Grain predictor state and register copies
  logic [GRAIN_SIZE_W-1:0]   size_setting;
  logic [GRAIN_COUNT_W-1:0]  count_setting;
  logic [GRAIN_SIZE_W-1:0]   cells_in_grain;
  logic [GRAIN_COUNT_W-1:0]  grains_closed;
  logic [GRAIN_COUNT_W-1:0]  grains_stored;
  logic [GRAIN_STATES_W-1:0] states_acc;
  logic [WSUM_W-1:0]         weighted_acc;

  grain_t expected_grains[$];
  int     errors = 0;
  int     cells_sent = 0;
  bit     idle_on = 1'b1;
  bit     hold_req = 1'b0;
  bit     zero_grain = 1'b0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Fold one cell into the open grain; return 1 with the grain when it closes.
  function automatic bit predict_grain(input cell_t c, output grain_t g);
    logic [GRAIN_SIZE_W-1:0]   size_eff;
    logic [GRAIN_COUNT_W-1:0]  count_eff;
    logic [GRAIN_STATES_W:0]   states_next;
    logic [WSUM_W:0]           weighted_next;
    logic [WSUM_W-1:0]         prod;
    logic [WSUM_W-1:0]         mean;
    size_eff = (size_setting == '0) ? GRAIN_SIZE_W'(1) : size_setting;
    count_eff = (count_setting == '0) ? GRAIN_COUNT_W'(1) : count_setting;
    prod = WSUM_W'(c.cell_states) * WSUM_W'(c.cell_energy);
    states_next = (GRAIN_STATES_W + 1)'(states_acc) + (GRAIN_STATES_W + 1)'(c.cell_states);
    states_acc = states_next[GRAIN_STATES_W] ? '1 : states_next[GRAIN_STATES_W-1:0];
    weighted_next = (WSUM_W + 1)'(weighted_acc) + (WSUM_W + 1)'(prod);
    weighted_acc = weighted_next[WSUM_W] ? '1 : weighted_next[WSUM_W-1:0];
    cells_in_grain = cells_in_grain + GRAIN_SIZE_W'(1);
    g = '0;
    if (cells_in_grain != '0 && cells_in_grain < size_eff) return 1'b0;

    g.grain_states = states_acc;
    g.grain_position = grains_stored;
    g.grain_empty = (states_acc == '0);
    if (!g.grain_empty) begin
      mean = weighted_acc / WSUM_W'(states_acc);
      g.grain_mean_energy = (mean > WSUM_W'(MAX_ENERGY)) ? MAX_ENERGY : mean[CELL_ENERGY_W-1:0];
      grains_stored = grains_stored + GRAIN_COUNT_W'(1);
    end
    grains_closed = grains_closed + GRAIN_COUNT_W'(1);
    g.final_grain = (grains_closed == '0) || (grains_closed >= count_eff);
    if (g.final_grain) begin
      g.grains_short = (grains_stored < count_eff);
      grains_closed = '0;
      grains_stored = '0;
    end
    cells_in_grain = '0;
    states_acc = '0;
    weighted_acc = '0;
    return 1'b1;
  endfunction

  function automatic grain_t grain_of(input logic [GRAIN_STATES_W-1:0] states,
                                      input logic [CELL_ENERGY_W-1:0] mean,
                                      input logic [GRAIN_COUNT_W-1:0] pos,
                                      input logic empty, input logic fin,
                                      input logic shortfall);
    grain_t g;
    g.grain_states = states;
    g.grain_mean_energy = mean;
    g.grain_position = pos;
    g.grain_empty = empty;
    g.final_grain = fin;
    g.grains_short = shortfall;
    return g;
  endfunction

  function automatic stim_row_t cell_row(input logic [CELL_STATES_W-1:0] states,
                                         input logic [CELL_ENERGY_W-1:0] energy);
    stim_row_t r;
    r.kind = ROW_CELL;
    r.write = '0;
    r.cell_data.cell_states = states;
    r.cell_data.cell_energy = energy;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [CELL_STATES_W-1:0] states,
                                            input logic [CELL_ENERGY_W-1:0] energy,
                                            input grain_t want);
    stim_row_t r;
    r = cell_row(states, energy);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = cell_row('0, '0);
    r.kind = ROW_WRITE;
    r.write.index = index;
    r.write.data = data;
    return r;
  endfunction

  // Empty grains need every cell at zero, so pick them per grain.
  function automatic cell_t random_cell();
    cell_t       c;
    logic [63:0] r64;
    if (cells_in_grain == '0) zero_grain = ($urandom_range(0, 5) == 0);
    r64 = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: c.cell_states = '0;
      1: c.cell_states = MAX_STATES;
      2: c.cell_states = CELL_STATES_W'($urandom_range(1, 255));
      3: c.cell_states = CELL_STATES_W'(1) << $urandom_range(0, CELL_STATES_W - 1);
      default: c.cell_states = r64[CELL_STATES_W-1:0];
    endcase
    if (zero_grain) c.cell_states = '0;
    case ($urandom_range(0, 7))
      0: c.cell_energy = '0;
      1: c.cell_energy = MAX_ENERGY;
      2: c.cell_energy = CELL_ENERGY_W'($urandom_range(0, 15));
      default: c.cell_energy = CELL_ENERGY_W'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_cell(input cell_t c, input bit typed, input grain_t typed_want);
    grain_t g;
    int     gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      cells_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells_if.valid <= 1'b1;
    cells_if.payload <= c;
    do @(posedge clk); while (!cells_if.ready);
    cells_sent++;
    if (predict_grain(c, g)) expected_grains = {expected_grains, typed ? typed_want : g};
  endtask

  // Write only with the block drained; a mid-grain cell may still be in flight.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_t w;
    w.index = index;
    w.data = data;
    cells_if.valid <= 1'b0;
    while (expected_grains.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (index == REG_GRAIN_SIZE) size_setting = data[GRAIN_SIZE_W-1:0];
    else if (index == REG_GRAIN_COUNT) count_setting = data;
  endtask

  initial begin : grain_sink
    int     stall_left;
    int     hold_left;
    int     grains_seen_out;
    grain_t got;
    grain_t want;
    stall_left = 0;
    hold_left = 0;
    grains_seen_out = 0;
    grains_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (grains_if.valid && grains_if.ready) begin
        got = grains_if.payload;
        grains_seen_out++;
        if (expected_grains.size() == 0) begin
          report_mismatch($sformatf("grain %0d arrived with none expected", grains_seen_out));
        end else begin
          want = expected_grains.pop_front();
          if (got.grain_states !== want.grain_states)
            report_mismatch($sformatf("grain %0d grain_states %h, want %h",
                                      grains_seen_out, got.grain_states, want.grain_states));
          if (got.grain_mean_energy !== want.grain_mean_energy)
            report_mismatch($sformatf("grain %0d grain_mean_energy %h, want %h", grains_seen_out,
                                      got.grain_mean_energy, want.grain_mean_energy));
          if (got.grain_position !== want.grain_position)
            report_mismatch($sformatf("grain %0d grain_position %0d, want %0d", grains_seen_out,
                                      got.grain_position, want.grain_position));
          if (got.grain_empty !== want.grain_empty)
            report_mismatch($sformatf("grain %0d grain_empty %b, want %b",
                                      grains_seen_out, got.grain_empty, want.grain_empty));
          if (got.final_grain !== want.final_grain)
            report_mismatch($sformatf("grain %0d final_grain %b, want %b",
                                      grains_seen_out, got.final_grain, want.final_grain));
          if (got.grains_short !== want.grains_short)
            report_mismatch($sformatf("grain %0d grains_short %b, want %b",
                                      grains_seen_out, got.grains_short, want.grains_short));
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        grains_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        grains_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        grains_if.ready <= 1'b0;
      end else begin
        grains_if.ready <= 1'b1;
      end
    end
  end

  initial begin : cell_source
    stim_row_t    directed_rows[$];
    logic [15:0]  size_data;
    logic [15:0]  count_data;
    int           n;
    int           phase;

    rst <= 1'b1;
    cells_if.valid <= 1'b0;
    cells_if.payload <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.payload <= '0;
    size_setting = GRAIN_SIZE_W'(1);
    count_setting = GRAIN_COUNT_W'(1);
    cells_in_grain = '0;
    grains_closed = '0;
    grains_stored = '0;
    states_acc = '0;
    weighted_acc = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      checked_row('0, '0, grain_of('0, '0, '0, 1'b1, 1'b1, 1'b1)),
      checked_row('0, MAX_ENERGY, grain_of('0, '0, '0, 1'b1, 1'b1, 1'b1)),
      checked_row(MAX_STATES, MAX_ENERGY,
                  grain_of(GRAIN_STATES_W'(MAX_STATES), MAX_ENERGY, '0, 1'b0, 1'b1, 1'b0)),
      checked_row(CELL_STATES_W'(1), MAX_ENERGY,
                  grain_of(GRAIN_STATES_W'(1), MAX_ENERGY, '0, 1'b0, 1'b1, 1'b0)),
      checked_row(MAX_STATES, '0,
                  grain_of(GRAIN_STATES_W'(MAX_STATES), '0, '0, 1'b0, 1'b1, 1'b0)),
      // zero in either register behaves as one
      write_row(REG_GRAIN_SIZE, '0),
      write_row(REG_GRAIN_COUNT, '0),
      checked_row(CELL_STATES_W'(256), CELL_ENERGY_W'(5),
                  grain_of(GRAIN_STATES_W'(256), CELL_ENERGY_W'(5), '0, 1'b0, 1'b1, 1'b0)),
      write_row(REG_GRAIN_SIZE, CFG_DATA_W'(15)),
      write_row(REG_GRAIN_COUNT, CFG_DATA_W'(3))
    };
    for (int i = 0; i < 15; i++) begin
      directed_rows = {directed_rows,
                       i[0] ? cell_row(CELL_STATES_W'(40'h55_5555_5555), 20'hAAAAA)
                            : cell_row(MAX_STATES, MAX_ENERGY)};
    end
    // shrink the size under an open grain, then the count under an open run
    directed_rows = {directed_rows, cell_row(CELL_STATES_W'(3), CELL_ENERGY_W'(7))};
    directed_rows = {directed_rows, write_row(REG_GRAIN_SIZE, CFG_DATA_W'(1))};
    directed_rows = {directed_rows, cell_row(CELL_STATES_W'(5), CELL_ENERGY_W'(1))};
    directed_rows = {directed_rows, write_row(REG_GRAIN_COUNT, CFG_DATA_W'(2))};
    directed_rows = {directed_rows, cell_row('0, '0)};
    directed_rows = {directed_rows, write_row(REG_UNUSED_TOP, '1)};
    directed_rows = {directed_rows, write_row(REG_GRAIN_SIZE, CFG_DATA_W'(16'hFFF4))};
    directed_rows = {directed_rows, write_row(REG_GRAIN_COUNT, '1)};
    directed_rows = {directed_rows, cell_row(MAX_STATES, CELL_ENERGY_W'(1))};
    directed_rows = {directed_rows, cell_row(CELL_STATES_W'(2), MAX_ENERGY)};

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_reg(directed_rows[i].write.index, directed_rows[i].write.data);
      else
        send_cell(directed_rows[i].cell_data, directed_rows[i].typed, directed_rows[i].want);
    end

    phase = 0;
    while (cells_sent < TOTAL_CELLS) begin
      idle_on = (cells_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if (phase == PRESSURE_PHASE) begin
        // hold the sink off while cells keep coming so the block backs up
        write_reg(REG_GRAIN_SIZE, CFG_DATA_W'(1));
        hold_req = 1'b1;
        n = 40;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 7))
            0: size_data = '0;
            1: size_data = CFG_DATA_W'(15);
            2, 3: size_data = CFG_DATA_W'(1);
            4: size_data = CFG_DATA_W'(2);
            default: size_data = CFG_DATA_W'($urandom_range(1, 15));
          endcase
          if ($urandom_range(0, 3) == 0)
            size_data[CFG_DATA_W-1:GRAIN_SIZE_W] = (CFG_DATA_W - GRAIN_SIZE_W)'($urandom);
          write_reg(REG_GRAIN_SIZE, size_data);
        end
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 6))
            0: count_data = '0;
            1: count_data = '1;
            2: count_data = CFG_DATA_W'(1);
            default: count_data = CFG_DATA_W'($urandom_range(2, 12));
          endcase
          write_reg(REG_GRAIN_COUNT, count_data);
        end
        if ($urandom_range(0, 9) == 0)
          write_reg(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
        n = $urandom_range(4, 40);
      end
      repeat (n) send_cell(random_cell(), 1'b0, '0);
      phase++;
    end

    cells_if.valid <= 1'b0;
    while (expected_grains.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
